@@ rtl/lztcm_pkg.sv @@
package lztcm_pkg;

  // Model group codes carried on each triple
  localparam logic [2:0] GRP_FLAG   = 3'd0;
  localparam logic [2:0] GRP_LIT    = 3'd1;
  localparam logic [2:0] GRP_LEN    = 3'd2;
  localparam logic [2:0] GRP_LSUF   = 3'd3;
  localparam logic [2:0] GRP_OFSPRE = 3'd4;
  localparam logic [2:0] GRP_OFSSUF = 3'd5;

  // Token kinds
  localparam logic MODE_LITERAL = 1'b0;
  localparam logic MODE_MATCH   = 1'b1;

  // Most triples one token can produce
  localparam int TRIP_MAX = 5;

  // Shortest match length
  localparam logic [11:0] MIN_LEN = 12'd5;

  // Symbol for a zero literal byte
  localparam logic [9:0] SYM_ZERO_BYTE = 10'd256;

  typedef struct packed {
    logic [2:0] model_group;
    logic [8:0] context_index;
    logic [9:0] symbol;
    logic       last_of_token;
  } triple_t;

endpackage

@@ rtl/lztcm_in_if.sv @@
interface lztcm_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [7:0]  byte_value;
  logic [14:0] file_id;
  logic [11:0] match_length;
  logic [7:0]  next_ref_byte;

  modport source (
    output valid, mode, byte_value, file_id, match_length, next_ref_byte,
    input  ready
  );
  modport sink (
    input  valid, mode, byte_value, file_id, match_length, next_ref_byte,
    output ready
  );
endinterface

@@ rtl/lztcm_out_if.sv @@
interface lztcm_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] model_group;
  logic [8:0] context_index;
  logic [9:0] symbol;
  logic       last_of_token;

  modport source (
    output valid, model_group, context_index, symbol, last_of_token,
    input  ready
  );
  modport sink (
    input  valid, model_group, context_index, symbol, last_of_token,
    output ready
  );
endinterface

@@ rtl/lztcm_recent_cache.sv @@
module lztcm_recent_cache #(
  parameter int RECENT_DEPTH = 4,
  parameter int PW = (RECENT_DEPTH > 1) ? $clog2(RECENT_DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [14:0]   lookup_id,
  input  logic          upd_en,
  output logic          hit,
  output logic [PW-1:0] pos
);

  logic [14:0]   ent_r   [RECENT_DEPTH];
  logic [14:0]   ent_nxt [RECENT_DEPTH];
  logic [PW-1:0] move_pos;

  // Find the lowest matching entry
  always_comb begin
    hit = 1'b0;
    pos = '0;
    for (int i = RECENT_DEPTH - 1; i >= 0; i--) begin
      if (ent_r[i] == lookup_id) begin
        hit = 1'b1;
        pos = PW'(i);
      end
    end
  end

  // Move to front: shift entries up to the hit (or the whole list on a miss)
  assign move_pos = hit ? pos : PW'(RECENT_DEPTH - 1);

  always_comb begin
    ent_nxt[0] = lookup_id;
    for (int j = 1; j < RECENT_DEPTH; j++) begin
      ent_nxt[j] = (PW'(j) <= move_pos) ? ent_r[j-1] : ent_r[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < RECENT_DEPTH; k++) begin
        ent_r[k] <= '0;
      end
    end else if (upd_en) begin
      for (int k = 0; k < RECENT_DEPTH; k++) begin
        ent_r[k] <= ent_nxt[k];
      end
    end
  end

endmodule

@@ rtl/lz_token_context_mapper_core.sv @@
// LZ token to range-coder triple mapper.
// in_ch takes one token per transfer: a literal byte (mode 0) or a match
// (mode 1: file id, length, reference byte after the match). out_ch gives
// the (model group, context index, symbol) triples of each token in order,
// last_of_token marking the final triple of the token.
// A literal gives 2 triples, a match 4 or 5. The output channel moves one
// triple per cycle when the receiver is ready. With the receiver always
// ready, the next token is taken in the cycle its predecessor's last
// triple moves, so tokens stream without gaps.
// The first triple of a token goes from the token buffer to the output
// register before it is valid on out_ch. The token buffer holds the
// triples of one token while the output register holds the triple on offer.
// When the receiver stalls, the output register holds its triple, the
// buffer holds its token and in_ch.ready drops until the buffer frees.
// Reset (rst_n low, synchronous) empties both stages and clears the flag,
// literal and length histories, the reference byte and the file cache
// (file 0 counts as cached at the front).
module lz_token_context_mapper_core #(
  parameter int RECENT_DEPTH  = 4,
  parameter int FLAG_CTX_BITS = 9,
  parameter int LEN_EXP       = 11
) (
  input logic       clk,
  input logic       rst_n,
  lztcm_in_if.sink  in_ch,
  lztcm_out_if.source out_ch
);
  import lztcm_pkg::*;

  localparam int PW = (RECENT_DEPTH > 1) ? $clog2(RECENT_DEPTH) : 1;
  localparam logic [15:0] MAX_LEN = 16'((1 << LEN_EXP) + 4);

  // State
  logic [FLAG_CTX_BITS-1:0] flag_r, flag_nxt;
  logic [15:0]              lit_r, lit_nxt;
  logic [3:0]               lctx_r, lctx_nxt;
  logic [7:0]               pend_r, pend_nxt;

  // Token buffer and output register
  triple_t    buf_r [TRIP_MAX];
  triple_t    trip  [TRIP_MAX];
  logic       buf_valid_r;
  logic [2:0] idx_r;
  triple_t    out_r;
  logic       out_valid_r;

  logic    in_fire, move, move_last;
  triple_t cur;

  // Datapath intermediates
  logic [31:0]              flag_ext;
  logic [FLAG_CTX_BITS:0]   flag_shift;
  logic [FLAG_CTX_BITS-1:0] flag_lit;
  logic [31:0]              flag_lit_ext;
  logic [4:0]               pop;
  logic [8:0]               lit_ctx;
  logic [9:0]               lit_sym;
  logic [11:0]              len_c, len_l;
  logic [3:0]               bkt;
  logic [11:0]              sfx;
  logic [5:0]               lctx_sum;
  logic                     c_hit;
  logic [PW-1:0]            c_pos;
  logic [9:0]               ofs_pre;
  logic [9:0]               ofs_suf;

  lztcm_recent_cache #(
    .RECENT_DEPTH (RECENT_DEPTH),
    .PW           (PW)
  ) u_cache (
    .clk       (clk),
    .rst_n     (rst_n),
    .lookup_id (in_ch.file_id),
    .upd_en    (in_fire && (in_ch.mode == MODE_MATCH)),
    .hit       (c_hit),
    .pos       (c_pos)
  );

  // Handshake: move a triple when the output register is free or drains
  assign cur        = buf_r[idx_r];
  assign move       = buf_valid_r && (!out_valid_r || out_ch.ready);
  assign move_last  = move && cur.last_of_token;
  assign in_ch.ready = !buf_valid_r || move_last;
  assign in_fire    = in_ch.valid && in_ch.ready;

  // Flag context and history
  assign flag_ext   = 32'(flag_r);
  assign flag_shift = {flag_r, in_ch.mode};
  assign flag_nxt   = flag_shift[FLAG_CTX_BITS-1:0];

  // Literal context: ones in the literal history plus updated flag bits
  always_comb begin
    pop = '0;
    for (int i = 0; i < 16; i++) begin
      pop = pop + 5'(lit_r[i]);
    end
  end

  assign flag_lit     = flag_shift[FLAG_CTX_BITS-1:0] & ~FLAG_CTX_BITS'(1);
  assign flag_lit_ext = 32'(flag_lit);
  assign lit_ctx      = {3'b0, flag_lit_ext[1:0], 4'b0} + {4'b0, pop};
  assign lit_sym      = (in_ch.byte_value == 8'd0) ? SYM_ZERO_BYTE
                      : {2'b0, in_ch.byte_value ^ pend_r};

  // Saturate the length and split it into bucket and suffix
  always_comb begin
    if (in_ch.match_length < MIN_LEN) begin
      len_c = MIN_LEN;
    end else if ({4'b0, in_ch.match_length} > MAX_LEN) begin
      len_c = MAX_LEN[11:0];
    end else begin
      len_c = in_ch.match_length;
    end
  end

  assign len_l = len_c - MIN_LEN;

  always_comb begin
    bkt = '0;
    for (int i = 0; i < 12; i++) begin
      if (len_l[i]) begin
        bkt = 4'(i + 1);
      end
    end
  end

  always_comb begin
    sfx = len_l;
    if (bkt > 4'd1) begin
      sfx[bkt - 4'd1] = 1'b0;
    end
  end

  // Length context: floor((3*ctx + bucket)/4), clamped
  assign lctx_sum = 6'(lctx_r) * 6'd3 + 6'(bkt);
  always_comb begin
    if (lctx_sum[5:2] > 4'(LEN_EXP)) begin
      lctx_nxt = 4'(LEN_EXP);
    end else begin
      lctx_nxt = lctx_sum[5:2];
    end
  end

  // Offset prefix and suffix from the file cache
  assign ofs_pre = c_hit ? 10'd0 : ({3'b0, in_ch.file_id[14:8]} + 10'd1);
  assign ofs_suf = c_hit ? 10'(c_pos) : {2'b0, in_ch.file_id[7:0]};

  // Build the triples of the incoming token
  always_comb begin
    trip[0] = '{GRP_FLAG, flag_ext[8:0], {9'b0, in_ch.mode}, 1'b0};
    if (in_ch.mode == MODE_LITERAL) begin
      trip[1] = '{GRP_LIT, lit_ctx, lit_sym, 1'b1};
      trip[2] = trip[1];
      trip[3] = trip[1];
      trip[4] = trip[1];
    end else begin
      trip[1] = '{GRP_LEN, {5'b0, lctx_r}, {6'b0, bkt}, 1'b0};
      if (bkt > 4'd1) begin
        trip[2] = '{GRP_LSUF, {5'b0, bkt}, sfx[9:0], 1'b0};
        trip[3] = '{GRP_OFSPRE, 9'd0, ofs_pre, 1'b0};
        trip[4] = '{GRP_OFSSUF, ofs_pre[8:0], ofs_suf, 1'b1};
      end else begin
        trip[2] = '{GRP_OFSPRE, 9'd0, ofs_pre, 1'b0};
        trip[3] = '{GRP_OFSSUF, ofs_pre[8:0], ofs_suf, 1'b1};
        trip[4] = trip[3];
      end
    end
  end

  // Next values of the token state
  always_comb begin
    lit_nxt  = lit_r;
    pend_nxt = pend_r;
    if (in_ch.mode == MODE_LITERAL) begin
      lit_nxt  = {lit_r[7:0], in_ch.byte_value};
      pend_nxt = 8'd0;
    end else begin
      pend_nxt = in_ch.next_ref_byte;
    end
  end

  // Advance the token state on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= '0;
      lit_r  <= '0;
      lctx_r <= '0;
      pend_r <= '0;
    end else if (in_fire) begin
      flag_r <= flag_nxt;
      lit_r  <= lit_nxt;
      pend_r <= pend_nxt;
      if (in_ch.mode == MODE_MATCH) begin
        lctx_r <= lctx_nxt;
      end
    end
  end

  // Token buffer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (in_fire) begin
      buf_valid_r <= 1'b1;
      idx_r       <= '0;
    end else if (move_last) begin
      buf_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (move) begin
      idx_r <= idx_r + 3'd1;
    end
  end

  // Load the buffer payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int k = 0; k < TRIP_MAX; k++) begin
        buf_r[k] <= trip[k];
      end
    end
  end

  // Output register: hold while stalled, drop after the transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_r <= cur;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.model_group   = out_r.model_group;
  assign out_ch.context_index = out_r.context_index;
  assign out_ch.symbol        = out_r.symbol;
  assign out_ch.last_of_token = out_r.last_of_token;

`ifndef SYNTH
  // A token transfer always leaves a full buffer starting at its flag
  a_fire_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (buf_valid_r && (idx_r == 3'd0) && (cur.model_group == GRP_FLAG)))
    else $error("token transfer did not load the buffer");

  // The buffer never runs past the longest token
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    buf_valid_r |-> (idx_r < 3'(TRIP_MAX)))
    else $error("triple index out of range");

  // Literal and offset suffix triples close a token, nothing else does
  a_last_group: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.last_of_token ==
      ((out_ch.model_group == GRP_LIT) || (out_ch.model_group == GRP_OFSSUF))))
    else $error("last_of_token on wrong group");

  // The length context stays within its clamp
  a_lctx_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    lctx_r <= 4'(LEN_EXP))
    else $error("length context above clamp");
`endif

endmodule
